### rtl/thbw_pkg.sv
// shared types and constants for the terrain height and blend weight pipeline
// used by thbw_div and terrain_height_blend_weights; no dependencies
`default_nettype none

package thbw_pkg;

    // Q1.15 one and the slope thresholds
    localparam logic [15:0] W_ONE       = 16'h8000;
    localparam logic [16:0] SLOPE_HALF  = 17'd16384;
    localparam logic [16:0] SLOPE_POINT4 = 17'd13107;

    // steep sand/grass blend divides by one minus 0.4 (19661); exact reciprocal
    // rounded up with 32 fraction bits over the 2^15 scale
    localparam logic [63:0] STEEP_SPAN       = 64'd19661;
    localparam logic [63:0] SLOPE_RECIP_FULL =
        ((64'd1 << 47) + STEEP_SPAN - 64'd1) / STEEP_SPAN;
    localparam logic [32:0] SLOPE_RECIP      = SLOPE_RECIP_FULL[32:0];

    // quotient bits of the height blend divider
    localparam int unsigned QBITS = 15;

    // configuration register indexes
    localparam logic [2:0] REG_Y_TRANSLATION = 3'd0;
    localparam logic [2:0] REG_MAX_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_MIN_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_SAND_LEVEL    = 3'd3;
    localparam logic [2:0] REG_GRASS_LEVEL   = 3'd4;
    localparam logic [2:0] REG_ROCK_LEVEL    = 3'd5;

    // height band codes
    typedef logic [2:0] t_band;
    localparam t_band BAND_FLOOR = 3'd0;
    localparam t_band BAND_SAND  = 3'd1;
    localparam t_band BAND_GRASS = 3'd2;
    localparam t_band BAND_ROCK  = 3'd3;
    localparam t_band BAND_TOP   = 3'd4;

    // per vertex values that ride along with the divider
    typedef struct packed {
        logic [31:0] y;
        t_band       band;
        logic        steep;
        logic [15:0] b_sg;
        logic [15:0] b_sr;
    } t_side;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        t_side       side;
    } t_div_in;

    typedef struct packed {
        logic [QBITS-1:0] quo;
        t_side            side;
    } t_div_out;

endpackage

`default_nettype wire

### rtl/thbw_div.sv
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^15 / den)
// for num below den; depends on thbw_pkg for the request and response structs
`default_nettype none

module thbw_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire thbw_pkg::t_div_in  i_req,
    output logic                    o_vld,
    output thbw_pkg::t_div_out      o_rsp
);
    import thbw_pkg::*;

    logic [QBITS-1:0] r_vld;
    logic [31:0]      r_rem  [QBITS-1];
    logic [31:0]      r_den  [QBITS-1];
    logic [QBITS-1:0] r_quo  [QBITS];
    t_side            r_side [QBITS];

    logic [31:0]      w_src_rem  [QBITS];
    logic [31:0]      w_src_den  [QBITS];
    logic [QBITS-1:0] w_src_quo  [QBITS];
    t_side            w_src_side [QBITS];
    logic [32:0]      w_shift    [QBITS];
    logic [32:0]      w_diff     [QBITS];
    logic [QBITS-1:0] w_ge;
    logic [31:0]      n_rem  [QBITS-1];
    logic [QBITS-1:0] n_quo  [QBITS];

    // stage sources and one shift-compare-subtract per stage
    always_comb begin
        w_src_rem[0]  = i_req.num;
        w_src_den[0]  = i_req.den;
        w_src_quo[0]  = '0;
        w_src_side[0] = i_req.side;
        for (int k = 1; k < QBITS; k++) begin
            w_src_rem[k]  = r_rem[k-1];
            w_src_den[k]  = r_den[k-1];
            w_src_quo[k]  = r_quo[k-1];
            w_src_side[k] = r_side[k-1];
        end
        for (int k = 0; k < QBITS; k++) begin
            w_shift[k] = {w_src_rem[k], 1'b0};
            w_diff[k]  = w_shift[k] - {1'b0, w_src_den[k]};
            w_ge[k]    = (w_shift[k] >= {1'b0, w_src_den[k]});
            n_quo[k]   = {w_src_quo[k][QBITS-2:0], w_ge[k]};
        end
        for (int k = 0; k < QBITS - 1; k++) begin
            n_rem[k] = w_ge[k] ? w_diff[k][31:0] : w_shift[k][31:0];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QBITS - 1; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_src_den[k];
            end
            for (int k = 0; k < QBITS; k++) begin
                r_quo[k]  <= n_quo[k];
                r_side[k] <= w_src_side[k];
            end
        end
    end

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QBITS-2:0], i_vld};
        end
    end

    assign o_vld      = r_vld[QBITS-1];
    assign o_rsp.quo  = r_quo[QBITS-1];
    assign o_rsp.side = r_side[QBITS-1];

endmodule

`default_nettype wire

### rtl/terrain_height_blend_weights.sv
// terrain vertex height and four texture blend weights; uses thbw_pkg and thbw_div
// pipeline: 9 front stages, 15 divider stages and the result register
// throughput: one beat per cycle; the whole pipeline holds while a result beat is stalled
// every stage is a register, so the rate stays at one beat per cycle; the 15 stage
// quotient pipeline, one bit per stage, sets most of the latency
// reset: synchronous active low, clears valid bits and loads register defaults
`default_nettype none

module terrain_height_blend_weights (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input beats
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic        [7:0]  i_height_code,
    input  wire logic signed [15:0] i_normal_x,
    // result beats
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed      [31:0] o_height,
    output logic             [15:0] o_weight_sand,
    output logic             [15:0] o_weight_grass,
    output logic             [15:0] o_weight_dirt,
    output logic             [15:0] o_weight_rock,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [4:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);
    import thbw_pkg::*;

    // ---------------- configuration registers ----------------
    logic [31:0] r_y_trans;
    logic [30:0] r_max_height;
    logic [31:0] r_min_height;
    logic [31:0] r_sand;
    logic [31:0] r_grass;
    logic [31:0] r_rock;
    logic        w_wr;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_trans    <= 32'd0;
            r_max_height <= 31'd6553600;
            r_min_height <= 32'd0;
            r_sand       <= 32'd1310720;
            r_grass      <= 32'd2162688;
            r_rock       <= 32'd6094848;
        end else if (w_wr) begin
            case (w_idx)
                REG_Y_TRANSLATION: r_y_trans    <= pwdata;
                REG_MAX_HEIGHT:    r_max_height <= pwdata[30:0];
                REG_MIN_HEIGHT:    r_min_height <= pwdata;
                REG_SAND_LEVEL:    r_sand       <= pwdata;
                REG_GRASS_LEVEL:   r_grass      <= pwdata;
                REG_ROCK_LEVEL:    r_rock       <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            REG_Y_TRANSLATION: prdata = r_y_trans;
            REG_MAX_HEIGHT:    prdata = {1'b0, r_max_height};
            REG_MIN_HEIGHT:    prdata = r_min_height;
            REG_SAND_LEVEL:    prdata = r_sand;
            REG_GRASS_LEVEL:   prdata = r_grass;
            REG_ROCK_LEVEL:    prdata = r_rock;
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic       w_adv;
    logic [8:0] r_pv;
    logic       r_out_vld;
    logic       w_div_vld;
    t_div_out   w_rsp;

    // everything moves when the result register is empty or being taken
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_pv      <= {r_pv[7:0], i_in_valid};
            r_out_vld <= w_div_vld;
        end
    end

    // ---------------- front stages ----------------
    logic [38:0] n1_p;
    logic [16:0] n1_s;
    logic [38:0] r1_p;
    logic [16:0] r1_s;

    logic [47:0] n2_s1;
    logic [16:0] w2_x;
    logic [47:0] r2_s1;
    logic [38:0] r2_p;
    logic [16:0] r2_s;
    logic [14:0] r2_x;

    logic [63:0] n3_s2;
    logic [47:0] n3_xm;
    logic [63:0] r3_s2;
    logic [38:0] r3_p;
    logic [16:0] r3_s;
    logic [47:0] r3_xm;

    logic [71:0] w4_tot;
    logic [16:0] w4_sr;
    logic [31:0] r4_q;
    logic [9:0]  r4_p10;
    logic [15:0] r4_bsg;
    logic [15:0] r4_bsr;
    logic        r4_steep;

    logic [9:0]  w5_rem;
    logic [31:0] n5_q;
    logic [30:0] r5_q;
    logic [15:0] r5_bsg;
    logic [15:0] r5_bsr;
    logic        r5_steep;

    logic [32:0] n6_sum;
    logic [32:0] r6_sum;
    logic [15:0] r6_bsg;
    logic [15:0] r6_bsr;
    logic        r6_steep;

    logic        w7_le;
    logic        w7_ovf;
    logic [31:0] n7_y;
    logic [31:0] r7_y;
    logic [15:0] r7_bsg;
    logic [15:0] r7_bsr;
    logic        r7_steep;

    logic [31:0] r8_y;
    logic        r8_le_min;
    logic        r8_lt_sand;
    logic        r8_lt_grass;
    logic        r8_lt_rock;
    logic [31:0] r8_ys;
    logic [31:0] r8_yg;
    logic [31:0] r8_gs;
    logic [31:0] r8_rg;
    logic [15:0] r8_bsg;
    logic [15:0] r8_bsr;
    logic        r8_steep;

    t_div_in     n9_req;
    t_div_in     r9_req;

    // stage 1: code times max height, slope magnitude
    assign n1_p = i_height_code * r_max_height;
    assign n1_s = i_normal_x[15] ? (17'd0 - {1'b1, i_normal_x}) : {1'b0, i_normal_x};

    // stage 2: first partial sum of the divide by 255 reciprocal, slope minus 0.4
    assign n2_s1 = {9'd0, r1_p} + {1'b0, r1_p, 8'd0};
    assign w2_x  = r1_s - SLOPE_POINT4;

    // stage 3: second partial sum, steep blend reciprocal product
    assign n3_s2 = {16'd0, r2_s1} + {r2_s1, 16'd0};
    assign n3_xm = 48'(r2_x) * 48'(SLOPE_RECIP);

    // stage 4: quotient estimate, low by at most one; slope minus half and steep flag
    assign w4_tot = {8'd0, r3_s2} + {1'b0, r3_p, 32'd0};
    assign w4_sr  = r3_s - SLOPE_HALF;

    // stage 5: remainder check on the low bits corrects the estimate
    assign w5_rem = r4_p10 - {r4_q[1:0], 8'd0} + r4_q[9:0];
    assign n5_q   = r4_q + 32'(w5_rem >= 10'd255);

    // stage 6: add the offset
    assign n6_sum = {r_y_trans[31], r_y_trans} + {2'b00, r5_q};

    // stage 7: floor at min height, then saturate
    assign w7_le  = $signed(r6_sum) <= $signed({r_min_height[31], r_min_height});
    assign w7_ovf = $signed(r6_sum) > $signed(33'h0_7FFF_FFFF);
    always_comb begin
        if (w7_le) begin
            n7_y = r_min_height;
        end else if (w7_ovf) begin
            n7_y = 32'h7FFF_FFFF;
        end else begin
            n7_y = r6_sum[31:0];
        end
    end

    // stage 9: pick the band and the divider operands
    always_comb begin
        if (r8_le_min) begin
            n9_req.side.band = BAND_FLOOR;
        end else if (r8_lt_sand) begin
            n9_req.side.band = BAND_SAND;
        end else if (r8_lt_grass) begin
            n9_req.side.band = BAND_GRASS;
        end else if (r8_lt_rock) begin
            n9_req.side.band = BAND_ROCK;
        end else begin
            n9_req.side.band = BAND_TOP;
        end
        if (n9_req.side.band == BAND_GRASS) begin
            n9_req.num = r8_ys;
            n9_req.den = r8_gs;
        end else begin
            n9_req.num = r8_yg;
            n9_req.den = r8_rg;
        end
        n9_req.side.y     = r8_y;
        n9_req.side.steep = r8_steep;
        n9_req.side.b_sg  = r8_bsg;
        n9_req.side.b_sr  = r8_bsr;
    end

    // front stage registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p <= n1_p;
            r1_s <= n1_s;

            r2_s1 <= n2_s1;
            r2_p  <= r1_p;
            r2_s  <= r1_s;
            r2_x  <= w2_x[14:0];

            r3_s2 <= n3_s2;
            r3_p  <= r2_p;
            r3_s  <= r2_s;
            r3_xm <= n3_xm;

            r4_q     <= w4_tot[71:40];
            r4_p10   <= r3_p[9:0];
            r4_bsg   <= r3_xm[47:32];
            r4_bsr   <= {w4_sr[14:0], 1'b0};
            r4_steep <= (r3_s > SLOPE_HALF);

            r5_q     <= n5_q[30:0];
            r5_bsg   <= r4_bsg;
            r5_bsr   <= r4_bsr;
            r5_steep <= r4_steep;

            r6_sum   <= n6_sum;
            r6_bsg   <= r5_bsg;
            r6_bsr   <= r5_bsr;
            r6_steep <= r5_steep;

            r7_y     <= n7_y;
            r7_bsg   <= r6_bsg;
            r7_bsr   <= r6_bsr;
            r7_steep <= r6_steep;

            r8_y        <= r7_y;
            r8_le_min   <= $signed(r7_y) <= $signed(r_min_height);
            r8_lt_sand  <= $signed(r7_y) < $signed(r_sand);
            r8_lt_grass <= $signed(r7_y) < $signed(r_grass);
            r8_lt_rock  <= $signed(r7_y) < $signed(r_rock);
            r8_ys       <= r7_y - r_sand;
            r8_yg       <= r7_y - r_grass;
            r8_gs       <= r_grass - r_sand;
            r8_rg       <= r_rock - r_grass;
            r8_bsg      <= r7_bsg;
            r8_bsr      <= r7_bsr;
            r8_steep    <= r7_steep;

            r9_req <= n9_req;
        end
    end

    // ---------------- height blend divider ----------------
    thbw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_pv[8]),
        .i_req   (r9_req),
        .o_vld   (w_div_vld),
        .o_rsp   (w_rsp)
    );

    // ---------------- weights and result register ----------------
    logic [15:0] w_q16;
    logic [15:0] n_w_sand;
    logic [15:0] n_w_grass;
    logic [15:0] n_w_dirt;
    logic [15:0] n_w_rock;
    logic [31:0] r_out_height;
    logic [15:0] r_out_sand;
    logic [15:0] r_out_grass;
    logic [15:0] r_out_dirt;
    logic [15:0] r_out_rock;

    assign w_q16 = {1'b0, w_rsp.quo};

    // weights per band
    always_comb begin
        n_w_sand  = 16'd0;
        n_w_grass = 16'd0;
        n_w_dirt  = 16'd0;
        n_w_rock  = 16'd0;
        case (w_rsp.side.band)
            BAND_FLOOR: begin
                n_w_sand  = W_ONE;
                n_w_grass = W_ONE;
            end
            BAND_SAND: begin
                n_w_sand = W_ONE;
            end
            BAND_GRASS: begin
                if (w_rsp.side.steep) begin
                    n_w_grass = w_rsp.side.b_sg;
                    n_w_dirt  = W_ONE - w_rsp.side.b_sg;
                end else begin
                    n_w_sand  = W_ONE - w_q16;
                    n_w_grass = w_q16;
                end
            end
            BAND_ROCK: begin
                if (w_rsp.side.steep) begin
                    n_w_dirt = w_rsp.side.b_sr;
                    n_w_rock = W_ONE - w_rsp.side.b_sr;
                end else begin
                    n_w_grass = W_ONE - w_q16;
                    n_w_dirt  = w_q16;
                end
            end
            BAND_TOP: begin
                n_w_rock = W_ONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_height <= w_rsp.side.y;
            r_out_sand   <= n_w_sand;
            r_out_grass  <= n_w_grass;
            r_out_dirt   <= n_w_dirt;
            r_out_rock   <= n_w_rock;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_height       = r_out_height;
    assign o_weight_sand  = r_out_sand;
    assign o_weight_grass = r_out_grass;
    assign o_weight_dirt  = r_out_dirt;
    assign o_weight_rock  = r_out_rock;

`ifndef NO_ASSERTIONS
    // weights sum to one, except the doubled floor band
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({2'b00, o_weight_sand} + {2'b00, o_weight_grass} +
                          {2'b00, o_weight_dirt} + {2'b00, o_weight_rock}) == 18'd32768) ||
                        (o_weight_sand == W_ONE && o_weight_grass == W_ONE))
        else $error("blend weights do not sum to one");

    // delivered height never below the floor
    a_height_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_height) >= $signed(r_min_height))
        else $error("height below min_height");

    // at most two textures blend at once
    a_two_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_weight_sand != 16'd0, o_weight_grass != 16'd0,
                                    o_weight_dirt != 16'd0, o_weight_rock != 16'd0}) <= 2)
        else $error("more than two nonzero blend weights");
`endif

endmodule

`default_nettype wire
